// File: sv/lmxi_pkg.sv
// lmxi_pkg: shared types and constants of the led matrix xy-to-index mapper
// no dependencies; used by every other file of the block
package lmxi_pkg;

  localparam int unsigned POS_W      = 8;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned ROT_W      = 3;

  // rotation flag bit positions, applied in this order
  localparam int unsigned ROT_90_BIT  = 0;
  localparam int unsigned ROT_180_BIT = 1;
  localparam int unsigned ROT_270_BIT = 2;

  localparam logic [DIM_W-1:0] PHYS_WIDTH_RST  = 8'd16;
  localparam logic [DIM_W-1:0] PHYS_HEIGHT_RST = 8'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHYS_WIDTH      = 3'd0,
    REG_PHYS_HEIGHT     = 3'd1,
    REG_ROTATION_FLAGS  = 3'd2,
    REG_FLIP_HORIZONTAL = 3'd3,
    REG_FLIP_VERTICAL   = 3'd4,
    REG_COLUMN_MAJOR    = 3'd5,
    REG_STRAIGHT_ROWS   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] phys_width;
    logic [DIM_W-1:0] phys_height;
    logic [ROT_W-1:0] rotation_flags;
    logic             flip_horizontal;
    logic             flip_vertical;
    logic             column_major;
    logic             straight_rows;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } pos_t;

  // after range check and rotation
  typedef struct packed {
    logic             outside;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } rot_t;

  // operands of the final multiply-add: index = mult_a * mult_b + addend
  typedef struct packed {
    logic               outside;
    logic [INDEX_W-1:0] mult_a;
    logic [DIM_W-1:0]   mult_b;
    logic [INDEX_W-1:0] addend;
  } lay_t;

  typedef struct packed {
    logic               outside;
    logic [INDEX_W-1:0] led_index;
  } res_t;

endpackage

// File: sv/lmxi_in_if.sv
// lmxi_in_if: valid/ready channel that carries one coordinate word
// depends on lmxi_pkg
interface lmxi_in_if import lmxi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// File: sv/lmxi_out_if.sv
// lmxi_out_if: valid/ready channel that carries one strip index word
// depends on lmxi_pkg
interface lmxi_out_if import lmxi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] led_index;
  logic               outside;

  modport source (output valid, output led_index, output outside, input ready);
  modport sink   (input valid, input led_index, input outside, output ready);
endinterface

// File: sv/lmxi_rotate.sv
// lmxi_rotate: first pipeline stage, visual range check and rotation
// depends on lmxi_pkg
module lmxi_rotate import lmxi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  pos_t pos_i,
  output logic valid_o,
  input  logic ready_i,
  output rot_t rot_o
);

  logic             valid_q;
  rot_t             rot_d, rot_q;
  logic             swap_dims;
  logic [DIM_W-1:0] vis_w, vis_h;
  logic [POS_W-1:0] x, y, t;

  always_comb begin
    swap_dims = cfg_i.rotation_flags[ROT_90_BIT] | cfg_i.rotation_flags[ROT_270_BIT];
    vis_w = swap_dims ? cfg_i.phys_height : cfg_i.phys_width;
    vis_h = swap_dims ? cfg_i.phys_width : cfg_i.phys_height;
    x = pos_i.pos_x;
    y = pos_i.pos_y;
    t = '0;
    // each step wraps to 8 bits
    if (cfg_i.rotation_flags[ROT_90_BIT]) begin
      t = x;
      x = cfg_i.phys_width - 8'd1 - y;
      y = t;
    end
    if (cfg_i.rotation_flags[ROT_180_BIT]) begin
      x = cfg_i.phys_width - 8'd1 - x;
      y = cfg_i.phys_height - 8'd1 - y;
    end
    if (cfg_i.rotation_flags[ROT_270_BIT]) begin
      t = x;
      x = y;
      y = cfg_i.phys_height - 8'd1 - t;
    end
    rot_d.outside = (pos_i.pos_x >= vis_w) || (pos_i.pos_y >= vis_h);
    rot_d.x = x;
    rot_d.y = y;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

// File: sv/lmxi_layout.sv
// lmxi_layout: second pipeline stage, mirrors, axis swap and line direction
// depends on lmxi_pkg; produces the operands of the multiply-add
module lmxi_layout import lmxi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  rot_t rot_i,
  output logic valid_o,
  input  logic ready_i,
  output lay_t lay_o
);

  logic               valid_q;
  lay_t               lay_d, lay_q;
  logic [INDEX_W-1:0] minor, major, t;
  logic [DIM_W-1:0]   scale;

  always_comb begin
    minor = {{(INDEX_W-POS_W){1'b0}}, rot_i.x};
    major = {{(INDEX_W-POS_W){1'b0}}, rot_i.y};
    t     = '0;
    if (cfg_i.flip_horizontal) begin
      minor = {{(INDEX_W-DIM_W){1'b0}}, cfg_i.phys_width} - 16'd1 - minor;
    end
    if (cfg_i.flip_vertical) begin
      major = {{(INDEX_W-DIM_W){1'b0}}, cfg_i.phys_height} - 16'd1 - major;
    end
    if (cfg_i.column_major) begin
      t     = major;
      major = minor;
      minor = t;
      scale = cfg_i.phys_height;
    end else begin
      scale = cfg_i.phys_width;
    end
    lay_d.outside = rot_i.outside;
    lay_d.mult_b  = scale;
    if (cfg_i.straight_rows || !major[0]) begin
      lay_d.mult_a = major;
      lay_d.addend = minor;
    end else begin
      // reversed line: (major + 1) * scale - 1 - minor
      lay_d.mult_a = major + 16'd1;
      lay_d.addend = ~minor;
    end
    // outside: width times height through the same multiply-add
    if (rot_i.outside) begin
      lay_d.mult_a = {{(INDEX_W-DIM_W){1'b0}}, cfg_i.phys_width};
      lay_d.mult_b = cfg_i.phys_height;
      lay_d.addend = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lay_q <= lay_d;
    end
  end

  assign valid_o = valid_q;
  assign lay_o   = lay_q;

endmodule

// File: sv/lmxi_index.sv
// lmxi_index: third and fourth pipeline stages, multiply then add
// depends on lmxi_pkg; the fourth stage is the output register
module lmxi_index import lmxi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  lay_t lay_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic                     mul_valid_q, res_valid_q;
  logic                     mul_ready, res_ready;
  logic [INDEX_W+DIM_W-1:0] prod_full;
  logic [INDEX_W-1:0]       prod_q, addend_q;
  logic                     outside_q;
  res_t                     res_d, res_q;

  assign prod_full = lay_i.mult_a * lay_i.mult_b;

  assign res_ready = !res_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || res_ready;
  assign ready_o   = mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_q <= valid_i;
      end
      if (res_ready) begin
        res_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && valid_i) begin
      prod_q    <= prod_full[INDEX_W-1:0];
      addend_q  <= lay_i.addend;
      outside_q <= lay_i.outside;
    end
  end

  assign res_d.outside   = outside_q;
  assign res_d.led_index = prod_q + addend_q;

  always_ff @(posedge clk_i) begin
    if (res_ready && mul_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_valid_q;
  assign res_o   = res_q;

endmodule

// File: sv/led_matrix_xy_to_index_top.sv
// Maps a visual (x, y) pixel coordinate to the strip index of an LED in a
// serpentine or straight matrix. One coordinate word is taken every clock
// unless the output stalls; its index word is built in the stages of range
// check and rotation, mirrors and layout, multiply and add. Each stage has its
// own valid bit, so a stall on the output holds the pipeline without losing a
// word and bubbles are filled. The seven layout registers are written through
// the cfg port and are to be changed only while no word is in flight.
module led_matrix_xy_to_index_top import lmxi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lmxi_in_if.sink               in_i,
  lmxi_out_if.source            out_o
);

  cfg_t cfg_q;
  pos_t pos;
  logic rot_valid, rot_ready;
  rot_t rot;
  logic lay_valid, lay_ready;
  lay_t lay;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phys_width      <= PHYS_WIDTH_RST;
      cfg_q.phys_height     <= PHYS_HEIGHT_RST;
      cfg_q.rotation_flags  <= '0;
      cfg_q.flip_horizontal <= 1'b0;
      cfg_q.flip_vertical   <= 1'b0;
      cfg_q.column_major    <= 1'b0;
      cfg_q.straight_rows   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PHYS_WIDTH:      cfg_q.phys_width      <= cfg_data_i[DIM_W-1:0];
        REG_PHYS_HEIGHT:     cfg_q.phys_height     <= cfg_data_i[DIM_W-1:0];
        REG_ROTATION_FLAGS:  cfg_q.rotation_flags  <= cfg_data_i[ROT_W-1:0];
        REG_FLIP_HORIZONTAL: cfg_q.flip_horizontal <= cfg_data_i[0];
        REG_FLIP_VERTICAL:   cfg_q.flip_vertical   <= cfg_data_i[0];
        REG_COLUMN_MAJOR:    cfg_q.column_major    <= cfg_data_i[0];
        REG_STRAIGHT_ROWS:   cfg_q.straight_rows   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign pos.pos_x = in_i.pos_x;
  assign pos.pos_y = in_i.pos_y;

  lmxi_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .pos_i   (pos),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .rot_o   (rot)
  );

  lmxi_layout u_layout (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .rot_i   (rot),
    .valid_o (lay_valid),
    .ready_i (lay_ready),
    .lay_o   (lay)
  );

  lmxi_index u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lay_valid),
    .ready_o (lay_ready),
    .lay_i   (lay),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.led_index = res.led_index;
  assign out_o.outside   = res.outside;

endmodule

// File: sv/lmxi_checker.sv
// lmxi_sva: port-level assertions on the mapper pipeline, bound to the top
// depends on lmxi_pkg and led_matrix_xy_to_index_top
module lmxi_sva import lmxi_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] led_index,
  input logic               outside
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a free output side never blocks the input side
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // an accepted word shows up at the output when the output is not stalled in between
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the output in time");

  // no word comes out of an empty, drained pipeline
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && out_ready) ##1 (!in_acc && out_ready) ##1 (!in_acc && out_ready)
      ##1 (!in_acc && out_ready) |=> !out_valid)
    else $error("word appeared without an accepted input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(led_index) && $stable(outside))
    else $error("stalled output word changed");

endmodule

bind led_matrix_xy_to_index_top lmxi_sva u_lmxi_sva (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .led_index (out_o.led_index),
  .outside   (out_o.outside)
);
